[design/tpdt_pkg.sv]
// Shared types and constants for the tolerant point dedup table.
// Depends on nothing; imported by tpdt_match and the top level.
package tpdt_pkg;

  localparam int COORD_W = 32;
  localparam int TOL_W   = 16;
  localparam int CAP_W   = 11;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'b1;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1074;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef enum logic [1:0] {
    ST_MATCHED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RESP
  } state_t;

  // Memory access request from the search sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_req_t;

endpackage

[design/tpdt_match.sv]
// Point store (one 96-bit word per slot, registered read) and per-axis tolerance compare.
// Depends on tpdt_pkg.
module tpdt_match import tpdt_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10
) (
  input  logic             clk,
  input  mem_req_t         req,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic [IDX_W-1:0] wr_addr,
  input  point_t           wr_data,
  input  point_t           probe,
  input  logic [TOL_W-1:0] tolerance,
  output logic             hit
);

  point_t mem [DEPTH];
  point_t rd_data_r;

  // |a - b| < tol, difference formed at 33 bits so it never wraps
  function automatic logic axis_close(input logic signed [COORD_W-1:0] a,
                                      input logic signed [COORD_W-1:0] b,
                                      input logic [TOL_W-1:0] tol);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0] mag;
    d   = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    mag = d[COORD_W] ? (~d + 1'b1) : d;
    return mag < {{(COORD_W+1-TOL_W){1'b0}}, tol};
  endfunction

  // Single write port, single registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Compare the word read last cycle against the probe point
  assign hit = axis_close(rd_data_r.x, probe.x, tolerance) &&
               axis_close(rd_data_r.y, probe.y, tolerance) &&
               axis_close(rd_data_r.z, probe.z, tolerance);

endmodule

[design/tolerant_point_dedup_table_top.sv]
// Top level of the tolerant point dedup table: handshakes, config registers, search sequencer.
// Depends on tpdt_pkg and tpdt_match.
//
//  port group | direction | word contents
//  in_*       | slave     | tdata: coord_x, coord_y, coord_z; tuser: begin_set
//  out_*      | master    | tdata: slot, status, stored_count
//  cfg_*      | write     | index 0 tolerance, index 1 capacity_limit
//
// The linear search reads one stored point per cycle through the single read port of the
// store and compares each point when its registered read returns; a match at slot k reads
// k + 1 points, and a miss waits for the last compare before the append or full decision.
// in_tready returns with out_tvalid, when the result is loaded into the output register.
// Reset (rst_n low, synchronous) empties the table and restores the config defaults.
// The next word is accepted while a result still waits in the output register.
// A stalled output only holds the sequencer once a second result is ready.
module tolerant_point_dedup_table_top import tpdt_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [95:0]          in_tdata,   // coord_x, coord_y, coord_z
  input  logic [0:0]           in_tuser,   // begin_set
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // slot, status, stored_count, zero pad
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOL_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

  // Config registers
  logic [TOL_W-1:0] tol_r;
  logic [CAP_W-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOLERANCE: tol_r <= cfg_wdata;
        CFG_CAPACITY:  cap_r <= cfg_wdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  point_t           point_r, point_nxt;
  logic [IDX_W-1:0] res_slot_r, res_slot_nxt;
  status_t          res_status_r, res_status_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [23:0]      out_data_r, out_data_nxt;

  mem_req_t         req;
  logic             hit;
  logic             in_acc;
  logic [CMP_W-1:0] cap_ext, limit, count_ext;
  logic [IDX_W+SLOT_W-1:0] slot_wide;
  logic [CNT_W+COUNT_W-1:0] count_wide;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Effective capacity: smaller of the limit register and the depth
  assign cap_ext   = CMP_W'(cap_r);
  assign count_ext = CMP_W'(count_r);
  assign limit     = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;

  // Output fields resized to the fixed result widths
  assign slot_wide  = {{SLOT_W{1'b0}}, res_slot_r};
  assign count_wide = {{COUNT_W{1'b0}}, count_r};

  tpdt_match #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_match (
    .clk       (clk),
    .req       (req),
    .rd_addr   (issue_r[IDX_W-1:0]),
    .wr_addr   (count_r[IDX_W-1:0]),
    .wr_data   (point_r),
    .probe     (point_r),
    .tolerance (tol_r),
    .hit       (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      issue_r   <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      issue_r   <= issue_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    point_r      <= point_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Next state: accept, search one slot per cycle, then hand result to output
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    point_nxt      = point_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_data_nxt   = out_data_r;
    req            = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          point_nxt = in_tdata;
          issue_nxt = '0;
          if (in_tuser[0]) begin
            count_nxt = '0;
          end
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        priority if (cmp_vld_r && hit) begin
          // first match in insertion order
          res_slot_nxt   = cmp_idx_r;
          res_status_nxt = ST_MATCHED;
          state_nxt      = S_RESP;
        end else if (issue_r == count_r && !cmp_vld_r) begin
          if (count_ext < limit) begin
            req.wr_en      = 1'b1;
            res_slot_nxt   = count_r[IDX_W-1:0];
            res_status_nxt = ST_INSERTED;
            count_nxt      = count_r + 1'b1;
          end else begin
            res_slot_nxt   = '0;
            res_status_nxt = ST_FULL;
          end
          state_nxt = S_RESP;
        end else begin
          if (issue_r < count_r) begin
            req.rd_en   = 1'b1;
            issue_nxt   = issue_r + 1'b1;
            cmp_vld_nxt = 1'b1;
            cmp_idx_nxt = issue_r[IDX_W-1:0];
          end
        end
      end
      S_RESP: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {1'b0, count_wide[COUNT_W-1:0], res_status_r,
                          slot_wide[SLOT_W-1:0]};
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Entry count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= DEPTH_C)
    else $error("entry count above table depth");

  // An insert grows the count by exactly one
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not advance entry count");

  // Only slots below the count are ever compared
  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> CNT_W'(cmp_idx_r) < count_r)
    else $error("compare on unfilled slot");

  // An accepted word always starts a search
  a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_SEARCH)
    else $error("accepted word did not start a search");

endmodule
